// ===== sv/afl_pkg.sv =====
// afl_pkg: shared types and constants for the audio flanger.
// Multiplier request/product types, sine polynomial constants, CSR codes.
// No dependencies.
package afl_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 66;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [MUL_W-1:0]  mul_opnd_type;
   typedef logic signed [PROD_W-1:0] mul_prod_type;

   typedef struct packed {
      logic         en;
      mul_opnd_type a;
      mul_opnd_type b;
   } mul_req_type;

   // sine polynomial y = x * (A - x^2 * (B - x^2 * C)), Q30
   localparam logic [30:0] SIN_A = 31'd1686629713;
   localparam logic [29:0] SIN_B = 30'd688904866;
   localparam logic [26:0] SIN_C = 27'd76016977;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_DEPTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DELAY  = 2'd2;

   localparam logic [15:0] MIX_DEPTH_RST = 16'd16384;
   localparam logic [9:0]  MAX_DELAY_RST = 10'd441;

endpackage

// ===== sv/afl_mul.sv =====
// afl_mul: shared signed 33x33 multiplier with registered product.
// Product holds while the request enable is low.
// Depends on afl_pkg.
module afl_mul
   import afl_pkg::*;
(
   input  logic         clock,
   input  mul_req_type  mul_req,
   output mul_prod_type prod
);

   mul_prod_type prod_ff;

   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= PROD_W'(mul_req.a) * PROD_W'(mul_req.b);
      end
   end

   assign prod = prod_ff;

endmodule

// ===== sv/afl_hist.sv =====
// afl_hist: history line of past output samples, one write and one read port.
// Read data is registered; entries are not cleared (validity tracked by the owner).
// Depends on afl_pkg.
module afl_hist
   import afl_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/audio_flanger.sv =====
// audio_flanger: top level; sequencer, LFO, delay offset and wet/dry mix.
// Uses afl_mul (shared multiplier) and afl_hist (history line); depends on afl_pkg.
//
// Flanger on signed 16-bit mono samples, one output beat per input beat. A new
// sample is accepted only in the idle state, so the next beat waits until the
// previous one is written back. Processing is the accept state and 11 multiplies
// in series through the single shared 33x33 multiplier (LFO index, sine
// polynomial, delay offset, dry and wet terms). The history read shares the
// dry multiply cycle. The take states and ST_SUM use a product without issuing
// a new one, and ST_DONE is the write-back state. Write-back waits while an earlier
// result is still held for rsp_ready. The output register lets a finished
// sample wait for rsp_ready while the next one is accepted and processed. A
// sample with req_last_in set restarts LFO phase and history. No clearing pass
// is needed, because unwritten history reads as zero.
module audio_flanger
   import afl_pkg::*;
#(
   parameter int LINE_DEPTH   = 1024,
   parameter int SINE_ENTRIES = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [SAMPLE_W-1:0]  req_sample_in,
   input  logic                        req_last_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SAMPLE_W-1:0]  rsp_sample_out,
   output logic                        rsp_last_out,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wr_data
);

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int FW = $clog2(LINE_DEPTH + 1);
   localparam int SB = $clog2(SINE_ENTRIES);
   localparam int NW = SB + 16;

   localparam mul_opnd_type  SE_OPND    = MUL_W'(SINE_ENTRIES);
   localparam mul_opnd_type  RECIP_OPND = MUL_W'(64'h1_0000_0000 / SINE_ENTRIES);
   localparam logic [NW-1:0] SE_REM     = NW'(SINE_ENTRIES);
   localparam logic [31:0]   DEPTH_M1   = 32'(LINE_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_EXT  = (AW + 1)'(LINE_DEPTH);
   localparam logic [FW-1:0] DEPTH_FILL = FW'(LINE_DEPTH);
   localparam logic [AW-1:0] WP_LAST    = AW'(LINE_DEPTH - 1);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_Q_MUL  = 5'd1;
   localparam logic [4:0] ST_P_MUL  = 5'd2;
   localparam logic [4:0] ST_R_MUL  = 5'd3;
   localparam logic [4:0] ST_R_TAKE = 5'd4;
   localparam logic [4:0] ST_X2_MUL = 5'd5;
   localparam logic [4:0] ST_C_MUL  = 5'd6;
   localparam logic [4:0] ST_C_TAKE = 5'd7;
   localparam logic [4:0] ST_T_MUL  = 5'd8;
   localparam logic [4:0] ST_T_TAKE = 5'd9;
   localparam logic [4:0] ST_Y_MUL  = 5'd10;
   localparam logic [4:0] ST_Y_TAKE = 5'd11;
   localparam logic [4:0] ST_D_MUL  = 5'd12;
   localparam logic [4:0] ST_K_MUL  = 5'd13;
   localparam logic [4:0] ST_K_TAKE = 5'd14;
   localparam logic [4:0] ST_RD     = 5'd15;
   localparam logic [4:0] ST_WET    = 5'd16;
   localparam logic [4:0] ST_SUM    = 5'd17;
   localparam logic [4:0] ST_DONE   = 5'd18;

   logic [4:0]                 state_ff, state_in;
   logic [31:0]                phase_ff, phase_in;
   logic [31:0]                phase_step_ff, phase_step_in;
   logic [15:0]                mix_depth_ff, mix_depth_in;
   logic [9:0]                 max_delay_ff, max_delay_in;
   logic [AW-1:0]              wp_ff, wp_in;
   logic [FW-1:0]              fill_ff, fill_in;
   logic signed [SAMPLE_W-1:0] dry_ff, dry_in;
   logic                       buf_last_ff, buf_last_in;
   logic [SB-1:0]              q_ff, q_in;
   logic [15:0]                p_ff, p_in;
   logic                       quad_ff, quad_in;
   logic [14:0]                r_ff, r_in;
   logic [30:0]                x2_ff, x2_in;
   logic [30:0]                t_ff, t_in;
   logic [14:0]                s_ff, s_in;
   logic [AW-1:0]              k_ff, k_in;
   logic signed [33:0]         acc_ff, acc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_last_ff, rsp_last_in;

   mul_req_type                mul_req;
   mul_prod_type               prod;
   logic [SAMPLE_W-1:0]        hist_rd_data;
   logic                       hist_rd_en;
   logic [AW-1:0]              hist_rd_addr;
   logic                       hist_wr_en;

   logic [NW-1:0]              rem;
   logic [15:0]                pfix;
   logic [33:0]                ysum;
   logic [18:0]                yq;
   logic [31:0]                kraw;
   logic [31:0]                kcl;
   logic [AW:0]                addr_diff;
   logic signed [SAMPLE_W-1:0] wet;
   logic signed [16:0]         dry_wt;
   logic signed [33:0]         biased;
   logic signed [18:0]         res_wide;
   logic signed [SAMPLE_W-1:0] res_sat;
   logic                       out_free;

   afl_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   afl_hist #(
      .DEPTH (LINE_DEPTH),
      .AW    (AW)
   ) u_hist (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (wp_ff),
      .wr_data (res_sat),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   // datapath helpers
   always_comb begin
      rem       = {q_ff, 16'h0000} - prod[NW-1:0];
      pfix      = p_ff + 16'(rem >= SE_REM);
      ysum      = {1'b0, prod[46:14]} + 34'd16384;
      yq        = ysum[33:15];
      kraw      = 32'(prod[40:30]);
      kcl       = (kraw > DEPTH_M1) ? DEPTH_M1 : kraw;
      addr_diff = {1'b0, wp_ff} - {1'b0, k_ff};
      if (addr_diff[AW]) begin
         addr_diff = addr_diff + DEPTH_EXT;
      end
      if (k_ff == '0) begin
         wet = dry_ff;
      end else if (FW'(k_ff) <= fill_ff) begin
         wet = $signed(hist_rd_data);
      end else begin
         wet = '0;
      end
      dry_wt   = 17'sd32768 - $signed({1'b0, mix_depth_ff});
      // divide by 32768 truncating toward zero
      biased   = acc_ff + (acc_ff[33] ? 34'sd32767 : 34'sd0);
      res_wide = biased[33:15];
      if (res_wide > 19'sd32767) begin
         res_sat = 16'sh7fff;
      end else if (res_wide < -19'sd32768) begin
         res_sat = 16'sh8000;
      end else begin
         res_sat = res_wide[15:0];
      end
      out_free = !rsp_valid_ff || rsp_ready;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      phase_step_in = phase_step_ff;
      mix_depth_in  = mix_depth_ff;
      max_delay_in  = max_delay_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      dry_in        = dry_ff;
      buf_last_in   = buf_last_ff;
      q_in          = q_ff;
      p_in          = p_ff;
      quad_in       = quad_ff;
      r_in          = r_ff;
      x2_in         = x2_ff;
      t_in          = t_ff;
      s_in          = s_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      mul_req       = '0;
      hist_rd_en    = 1'b0;
      hist_rd_addr  = addr_diff[AW-1:0];
      hist_wr_en    = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_PHASE_STEP: phase_step_in = csr_wr_data;
            CSR_MIX_DEPTH:  mix_depth_in  = csr_wr_data[15:0];
            CSR_MAX_DELAY:  max_delay_in  = csr_wr_data[9:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dry_in      = req_sample_in;
               buf_last_in = req_last_in;
               state_in    = ST_Q_MUL;
            end
         end
         ST_Q_MUL: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_W'(phase_ff);
            mul_req.b  = SE_OPND;
            state_in   = ST_P_MUL;
         end
         ST_P_MUL: begin
            q_in       = prod[32+SB-1:32];
            mul_req.en = 1'b1;
            mul_req.a  = MUL_W'({q_in, 16'h0000});
            mul_req.b  = RECIP_OPND;
            state_in   = ST_R_MUL;
         end
         ST_R_MUL: begin
            p_in       = prod[47:32];
            mul_req.en = 1'b1;
            mul_req.a  = MUL_W'(p_in);
            mul_req.b  = SE_OPND;
            state_in   = ST_R_TAKE;
         end
         ST_R_TAKE: begin
            quad_in = pfix[15];
            if (pfix[14]) begin
               r_in = 15'd16384 - {1'b0, pfix[13:0]};
            end else begin
               r_in = {1'b0, pfix[13:0]};
            end
            state_in = ST_X2_MUL;
         end
         ST_X2_MUL: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_W'(r_ff);
            mul_req.b  = MUL_W'(r_ff);
            state_in   = ST_C_MUL;
         end
         ST_C_MUL: begin
            x2_in      = {prod[28:0], 2'b00};
            mul_req.en = 1'b1;
            mul_req.a  = MUL_W'(SIN_C);
            mul_req.b  = MUL_W'(x2_in);
            state_in   = ST_C_TAKE;
         end
         ST_C_TAKE: begin
            t_in     = 31'(SIN_B) - 31'(prod[56:30]);
            state_in = ST_T_MUL;
         end
         ST_T_MUL: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_W'(t_ff);
            mul_req.b  = MUL_W'(x2_ff);
            state_in   = ST_T_TAKE;
         end
         ST_T_TAKE: begin
            t_in     = SIN_A - prod[60:30];
            state_in = ST_Y_MUL;
         end
         ST_Y_MUL: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_W'(t_ff);
            mul_req.b  = MUL_W'(r_ff);
            state_in   = ST_Y_TAKE;
         end
         ST_Y_TAKE: begin
            // negative half of the LFO gives no delay
            if (quad_ff) begin
               s_in = '0;
            end else if (yq > 19'd32767) begin
               s_in = 15'h7fff;
            end else begin
               s_in = yq[14:0];
            end
            state_in = ST_D_MUL;
         end
         ST_D_MUL: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_W'(s_ff);
            mul_req.b  = MUL_W'(mix_depth_ff);
            state_in   = ST_K_MUL;
         end
         ST_K_MUL: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_W'(prod[30:0]);
            mul_req.b  = MUL_W'(max_delay_ff);
            state_in   = ST_K_TAKE;
         end
         ST_K_TAKE: begin
            k_in     = kcl[AW-1:0];
            state_in = ST_RD;
         end
         ST_RD: begin
            hist_rd_en = 1'b1;
            mul_req.en = 1'b1;
            mul_req.a  = MUL_W'(dry_wt);
            mul_req.b  = MUL_W'(dry_ff);
            state_in   = ST_WET;
         end
         ST_WET: begin
            acc_in     = prod[33:0];
            mul_req.en = 1'b1;
            mul_req.a  = MUL_W'(mix_depth_ff);
            mul_req.b  = MUL_W'(wet);
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            acc_in   = acc_ff + prod[33:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               hist_wr_en    = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_sat;
               rsp_last_in   = buf_last_ff;
               if (buf_last_ff) begin
                  wp_in    = '0;
                  fill_in  = '0;
                  phase_in = '0;
               end else begin
                  wp_in    = (wp_ff == WP_LAST) ? '0 : wp_ff + 1'b1;
                  fill_in  = (fill_ff == DEPTH_FILL) ? fill_ff : fill_ff + 1'b1;
                  phase_in = phase_ff + phase_step_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= '0;
         phase_step_ff <= '0;
         mix_depth_ff  <= MIX_DEPTH_RST;
         max_delay_ff  <= MAX_DELAY_RST;
         wp_ff         <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         phase_step_ff <= phase_step_in;
         mix_depth_ff  <= mix_depth_in;
         max_delay_ff  <= max_delay_in;
         wp_ff         <= wp_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dry_ff        <= dry_in;
      buf_last_ff   <= buf_last_in;
      q_ff          <= q_in;
      p_ff          <= p_in;
      quad_ff       <= quad_in;
      r_ff          <= r_in;
      x2_ff         <= x2_in;
      t_ff          <= t_in;
      s_ff          <= s_in;
      k_ff          <= k_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_last_out   = rsp_last_ff;

endmodule

// ===== verif/audio_flanger_checker.sv =====
`timescale 1ns / 100ps
// audio_flanger_checker: watches the sample, result and CSR ports of the flanger,
// predicts every output beat and compares it field by field.
// Depends on afl_pkg.
module audio_flanger_checker
   import afl_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       req_last_in,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       rsp_last_out,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wr_data,
   output int                         fail_count,
   output int                         pending
);

   localparam int          LINE_N = 1024;
   localparam logic [63:0] SINE_N = 64'd256;
   localparam logic [63:0] POLY_A = 64'd1686629713;
   localparam logic [63:0] POLY_B = 64'd688904866;
   localparam logic [63:0] POLY_C = 64'd76016977;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } flange_beat_type;

   logic [SAMPLE_W-1:0] echo_line [LINE_N];
   logic [9:0]          echo_slot;
   logic [31:0]         lfo_acc;
   logic [31:0]         cfg_step;
   logic [15:0]         cfg_depth;
   logic [9:0]          cfg_delay;
   flange_beat_type     flange_due [$];

   // Q15 sine of the table entry addressed by the top of the LFO phase
   function automatic int lfo_sine(input logic [31:0] phase);
      logic [63:0] entry, turn, frac, x, x2, poly, y;
      logic [1:0]  quad;
      entry = ({32'd0, phase} * SINE_N) >> 32;
      turn  = (entry << 16) / SINE_N;
      quad  = turn[15:14];
      frac  = turn & 64'h3FFF;
      if (quad[0]) begin
         frac = 64'd16384 - frac;
      end
      x    = frac << 16;
      x2   = (x * x) >> 30;
      poly = POLY_B - ((POLY_C * x2) >> 30);
      poly = POLY_A - ((poly * x2) >> 30);
      y    = (poly * x) >> 30;
      y    = (y + 64'd16384) >> 15;
      if (y > 64'd32767) begin
         y = 64'd32767;
      end
      return quad[1] ? -int'(y) : int'(y);
   endfunction

   function automatic void clear_line();
      foreach (echo_line[i]) begin
         echo_line[i] = '0;
      end
      echo_slot = '0;
      lfo_acc   = '0;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] flange_sample(
      input logic signed [SAMPLE_W-1:0] dry,
      input logic                       last
   );
      int         sine, depth, wet;
      longint     prod, lag, mix, res;
      logic [9:0] tap;
      sine  = lfo_sine(lfo_acc);
      depth = int'(cfg_depth);
      prod  = longint'(sine) * depth * int'(cfg_delay);
      lag   = (prod > 0) ? (prod >>> 30) : 64'sd0;
      if (lag > LINE_N - 1) begin
         lag = LINE_N - 1;
      end
      // zero or negative offset: wet is the dry sample itself
      if (lag == 0) begin
         wet = dry;
      end else begin
         tap = echo_slot - lag[9:0];
         wet = $signed(echo_line[tap]);
      end
      mix = longint'(32768 - depth) * dry + longint'(depth) * wet;
      res = mix / 32768;
      if (res > 32767) begin
         res = 32767;
      end else if (res < -32768) begin
         res = -32768;
      end
      echo_line[echo_slot] = res[15:0];
      echo_slot = echo_slot + 10'd1;
      lfo_acc   = lfo_acc + cfg_step;
      if (last) begin
         clear_line();
      end
      return res[15:0];
   endfunction

   always @(posedge clock) begin
      flange_beat_type want;
      if (reset) begin
         flange_due.delete();
         clear_line();
         cfg_step  = '0;
         cfg_depth = MIX_DEPTH_RST;
         cfg_delay = MAX_DELAY_RST;
         pending   = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PHASE_STEP: cfg_step  = csr_wr_data;
               CSR_MIX_DEPTH:  cfg_depth = csr_wr_data[15:0];
               CSR_MAX_DELAY:  cfg_delay = csr_wr_data[9:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (flange_due.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with no sample outstanding: expected none, actual %0d/%0b",
                        $time, rsp_sample_out, rsp_last_out);
            end else begin
               want = flange_due.pop_front();
               if (rsp_sample_out !== want.sample) begin
                  fail_count++;
                  $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                           $time, $signed(want.sample), rsp_sample_out);
               end
               if (rsp_last_out !== want.last) begin
                  fail_count++;
                  $display("%0t: last_out mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_last_out);
               end
            end
         end
         if (req_valid && req_ready) begin
            want.last   = req_last_in;
            want.sample = flange_sample(req_sample_in, req_last_in);
            flange_due.push_back(want);
         end
         pending = flange_due.size();
      end
   end

endmodule

// ===== verif/audio_flanger_test.sv =====
`timescale 1ns / 100ps
// audio_flanger_test: stimulus, receiver backpressure, watchdog and verdict
// for audio_flanger. Depends on afl_pkg and audio_flanger_checker.
module audio_flanger_test;
   import afl_pkg::*;

   localparam int                   IDLE_LIMIT    = 3000;
   localparam int                   SETTLE_CYCLES = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE     = 2'd3;

   typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_CRAWL} rx_mode_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic                       req_last_in;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_last_out;
   logic                       csr_wr_en;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wr_data;
   int                         fail_count;
   int                         pending;

   int          samples_sent;
   int          buffers_closed;
   int          settings_used;
   int          idle_cycles;
   int          burst_left;
   int          buf_left;
   int          rx_span;
   rx_mode_type rx_mode;

   audio_flanger uut (.*);

   audio_flanger_checker flange_check (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver backpressure, changing character every so often
   always @(posedge clock) begin
      if (rx_span == 0) begin
         rx_span <= $urandom_range(16, 200);
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
      end else begin
         rx_span <= rx_span - 1;
      end
      case (rx_mode)
         RX_OPEN:  rsp_ready <= 1'b1;
         RX_COIN:  rsp_ready <= ($urandom_range(0, 1) == 0);
         RX_SLOW:  rsp_ready <= ($urandom_range(0, 7) == 0);
         default:  rsp_ready <= ($urandom_range(0, 31) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                  $time, IDLE_LIMIT, pending);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one sample beat, paced in bursts with random gaps
   task automatic put_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_sample_in <= value;
      req_last_in   <= last;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      samples_sent++;
      if (last) begin
         buffers_closed++;
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [31:0] lfo_step, input logic [15:0] depth_val,
                                input logic [9:0] delay_val);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PHASE_STEP;
      csr_wr_data <= lfo_step;
      @(posedge clock);
      csr_index   <= CSR_MIX_DEPTH;
      csr_wr_data <= {16'($urandom), depth_val};
      @(posedge clock);
      csr_index   <= CSR_MAX_DELAY;
      csr_wr_data <= {22'($urandom), delay_val};
      @(posedge clock);
      if ($urandom_range(0, 2) == 0) begin
         csr_index   <= CSR_SPARE;
         csr_wr_data <= $urandom;
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 15))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // buffers of random length, now and then very short ones
   function automatic logic close_buffer();
      if (buf_left == 0) begin
         buf_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(40, 1500);
      end
      buf_left--;
      return (buf_left == 0);
   endfunction

   initial begin
      int          phase_len;
      logic [31:0] lfo_step;
      logic [15:0] depth_val;
      logic [9:0]  delay_val;
      req_valid     <= 1'b0;
      req_sample_in <= '0;
      req_last_in   <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_PHASE_STEP;
      csr_wr_data   <= '0;
      reset         <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: LFO stands still, output follows input
      put_sample(16'sh7FFF, 1'b0);
      put_sample(16'sh8000, 1'b0);
      put_sample(16'sh0000, 1'b0);
      put_sample(-16'sd1, 1'b1);
      settle();

      // quarter-turn LFO: zero, crest, zero, trough (negative offset clamps)
      // crest reaches back into history that was never written
      load_settings(32'h4000_0000, 16'd32768, 10'd1023);
      put_sample(16'sh7FFF, 1'b0);
      put_sample(16'sh8000, 1'b0);
      put_sample(16'sh7FFF, 1'b0);
      put_sample(16'sh8000, 1'b0);
      put_sample(16'sd1, 1'b0);
      put_sample(-16'sd1, 1'b0);
      put_sample(16'sh0000, 1'b0);
      put_sample(16'sh7FFF, 1'b1);
      settle();

      // depth above unity, one-sample feedback: saturates at the positive limit
      load_settings(32'h4000_0000, 16'hFFFF, 10'd1);
      put_sample(16'sh7FFF, 1'b0);
      put_sample(16'sh8000, 1'b0);
      put_sample(16'sh7FFF, 1'b0);
      put_sample(16'sh8000, 1'b0);
      put_sample(16'sh7FFF, 1'b0);
      put_sample(16'sh8000, 1'b1);
      settle();

      // offset past the end of the line
      load_settings(32'h4000_0000, 16'hFFFF, 10'd1023);
      put_sample(16'sh8000, 1'b0);
      put_sample(16'sh7FFF, 1'b0);
      put_sample(16'sh8000, 1'b0);
      put_sample(16'sh7FFF, 1'b1);
      settle();

      // no depth, no delay, full-scale step
      load_settings(32'hFFFF_FFFF, 16'd0, 10'd0);
      put_sample(16'sh8000, 1'b0);
      put_sample(16'sh7FFF, 1'b0);
      put_sample(16'sh5A5A, 1'b1);
      settle();

      for (int ph = 0; ph < 8; ph++) begin
         phase_len = (ph == 2) ? 1100 : $urandom_range(60, 110);
         case ($urandom_range(0, 3))
            0:       lfo_step = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'd0;
            1:       lfo_step = $urandom_range(20000, 2000000);
            default: lfo_step = $urandom;
         endcase
         case ($urandom_range(0, 5))
            0:       depth_val = 16'd0;
            1:       depth_val = 16'd32768;
            2:       depth_val = 16'($urandom_range(32769, 65535));
            default: depth_val = 16'($urandom_range(0, 32768));
         endcase
         case ($urandom_range(0, 3))
            0:       delay_val = ($urandom_range(0, 1) == 0) ? 10'd1023 : 10'd0;
            default: delay_val = 10'($urandom_range(1, 1023));
         endcase
         // one long buffer so the write pointer wraps under a slow sweep
         if (ph == 2) begin
            lfo_step  = $urandom_range(1000000, 8000000);
            depth_val = 16'd32768;
            delay_val = 10'($urandom_range(300, 1023));
            buf_left  = 1200;
         end
         load_settings(lfo_step, depth_val, delay_val);
         repeat (phase_len) put_sample(pick_sample(), close_buffer());
         settle();
      end

      $display("Flanged %0d samples under %0d CSR settings, %0d buffer ends.",
               samples_sent, settings_used, buffers_closed);
      $display("Mismatches seen: %0d", fail_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
